[sv/ils_pkg.sv]
`timescale 1ns / 1ps
// ils_pkg: sizes, operation and status codes, and request/result types
// shared by the indexed list store. No dependencies.
package ils_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 16;
  localparam int DATA_W   = 32;
  localparam int OCNT_W   = 9;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] FN_READ     = 3'd0;
  localparam logic [2:0] FN_INS_HEAD = 3'd1;
  localparam logic [2:0] FN_INS_TAIL = 3'd2;
  localparam logic [2:0] FN_INS_POS  = 3'd3;
  localparam logic [2:0] FN_DELETE   = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [OCNT_W-1:0]        element_count;
  } rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic [1:0]        st;
    logic [CNT_W-1:0]  count;
  } seq_res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_ctl_t;

endpackage

[sv/ils_if.sv]
`timescale 1ns / 1ps
// ils_req_if / ils_rsp_if: valid/ready channels carrying requests and results.
// Depends on ils_pkg.
interface ils_req_if;
  logic          valid;
  logic          ready;
  ils_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ils_rsp_if;
  logic          valid;
  logic          ready;
  ils_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/indexed_list_store.sv]
`timescale 1ns / 1ps
// indexed_list_store: ordered list of signed 32-bit values packed in one RAM.
// Read: one RAM read, then the result is registered. Insert/delete: entries are
// shifted (one RAM read and one write per cycle), then the count is updated.
// A request that is out of range, refused as full, or unused skips the RAM.
// One request in flight; the next is taken while the last result waits.
// Reset (rst, synchronous) empties the list; RAM contents are left as they are.
// Depends on ils_pkg, ils_if, ils_ram, ils_seq.
module indexed_list_store (
  input  logic            clk,
  input  logic            rst,
  ils_req_if.sink         req,
  ils_rsp_if.source       rsp
);

  ils_pkg::ram_ctl_t             ram;
  logic [ils_pkg::DATA_W-1:0]    rdata;
  ils_pkg::seq_res_t             res;
  logic                          res_valid;
  logic                          res_ready;
  logic                          out_valid;
  ils_pkg::rsp_t                 out_data;
  logic [ils_pkg::CMP_W-1:0]     count_ext;

  ils_ram #(
    .DEPTH (ils_pkg::CAPACITY),
    .WIDTH (ils_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  ils_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_data  (req.payload),
    .ram       (ram),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || rsp.ready;
  assign count_ext = ils_pkg::CMP_W'(res.count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data.read_value    <= res.rd;
      out_data.status        <= res.st;
      out_data.element_count <= count_ext[ils_pkg::OCNT_W-1:0];
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  a_fail_no_value: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.payload.status != ils_pkg::ST_DONE
      |-> rsp.payload.read_value == -32'sd1)
    else $error("failed request carries a read value");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.payload.status == ils_pkg::ST_FULL
      |-> rsp.payload.element_count == ils_pkg::OCNT_W'(ils_pkg::CAPACITY))
    else $error("full status with list not full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.payload.element_count <= ils_pkg::OCNT_W'(ils_pkg::CAPACITY))
    else $error("element count beyond capacity");

endmodule

[sv/ils_ram.sv]
`timescale 1ns / 1ps
// ils_ram: simple dual-port synchronous RAM, one write and one registered read.
// No dependencies.
module ils_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/ils_seq.sv]
`timescale 1ns / 1ps
// ils_seq: decodes a request, checks it against the held count and runs the
// read or the one-entry-per-cycle shift through the RAM. Depends on ils_pkg.
module ils_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  ils_pkg::req_t                  req_data,
  output ils_pkg::ram_ctl_t              ram,
  input  logic [ils_pkg::DATA_W-1:0]     rdata,
  output logic                           res_valid,
  input  logic                           res_ready,
  output ils_pkg::seq_res_t              res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_FINAL  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                   state;
  logic [ils_pkg::CNT_W-1:0]    count;
  logic                         is_ins;
  logic                         pend;
  logic [ils_pkg::ADDR_W-1:0]   p_q;
  logic [ils_pkg::ADDR_W-1:0]   rd_idx;
  logic [ils_pkg::ADDR_W-1:0]   wr_addr;
  logic [ils_pkg::CNT_W-1:0]    left;
  logic [ils_pkg::DATA_W-1:0]   val_q;
  logic [ils_pkg::DATA_W-1:0]   res_rd;
  logic [1:0]                   res_st;

  logic                         neg;
  logic [ils_pkg::CMP_W-1:0]    pos_mag;
  logic [ils_pkg::CMP_W-1:0]    count_ext;
  logic                         in_range;
  logic                         past_end;
  logic                         full;
  logic                         go_read;
  logic                         go_shift;
  logic                         ins_op;
  logic [1:0]                   st_imm;
  logic [ils_pkg::CNT_W-1:0]    p_cnt;
  logic [ils_pkg::CNT_W-1:0]    moves;
  logic [ils_pkg::CNT_W-1:0]    start;
  logic                         accept;

  assign neg       = req_data.position[ils_pkg::POS_W-1];
  assign pos_mag   = ils_pkg::CMP_W'($unsigned(req_data.position));
  assign count_ext = ils_pkg::CMP_W'(count);
  assign in_range  = !neg && (pos_mag < count_ext);
  assign past_end  = !neg && (pos_mag > count_ext);
  assign full      = (count == ils_pkg::CNT_W'(ils_pkg::CAPACITY));
  assign accept    = req_valid && req_ready;

  always_comb begin
    go_read  = 1'b0;
    go_shift = 1'b0;
    ins_op   = 1'b1;
    st_imm   = ils_pkg::ST_DONE;
    p_cnt    = '0;
    case (req_data.func)
      ils_pkg::FN_READ: begin
        go_read = in_range;
        st_imm  = in_range ? ils_pkg::ST_DONE : ils_pkg::ST_RANGE;
      end
      ils_pkg::FN_INS_HEAD: begin
        go_shift = !full;
        st_imm   = full ? ils_pkg::ST_FULL : ils_pkg::ST_DONE;
      end
      ils_pkg::FN_INS_TAIL: begin
        go_shift = !full;
        st_imm   = full ? ils_pkg::ST_FULL : ils_pkg::ST_DONE;
        p_cnt    = count;
      end
      ils_pkg::FN_INS_POS: begin
        if (past_end) begin
          st_imm = ils_pkg::ST_RANGE;
        end else if (full) begin
          st_imm = ils_pkg::ST_FULL;
        end else begin
          go_shift = 1'b1;
          p_cnt    = neg ? '0 : ils_pkg::CNT_W'(pos_mag);
        end
      end
      ils_pkg::FN_DELETE: begin
        ins_op   = 1'b0;
        go_shift = in_range;
        st_imm   = in_range ? ils_pkg::ST_DONE : ils_pkg::ST_RANGE;
        p_cnt    = ils_pkg::CNT_W'(pos_mag);
      end
      default: begin
        st_imm = ils_pkg::ST_DONE;
      end
    endcase
    if (ins_op) begin
      moves = count - p_cnt;
      start = count - 1'b1;
    end else begin
      moves = count - p_cnt - 1'b1;
      start = p_cnt + 1'b1;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    ram.re    = (accept && go_read) || (state == S_SHIFT && left != '0);
    ram.raddr = (state == S_IDLE) ? ils_pkg::ADDR_W'(pos_mag) : rd_idx;
    ram.we    = (state == S_SHIFT && pend) || (state == S_FINAL && is_ins);
    ram.waddr = (state == S_FINAL) ? p_q : wr_addr;
    ram.wdata = (state == S_FINAL) ? val_q : rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_rd <= '1;
            res_st <= st_imm;
            is_ins <= ins_op;
            p_q    <= ils_pkg::ADDR_W'(p_cnt);
            val_q  <= req_data.value;
            left   <= moves;
            rd_idx <= ils_pkg::ADDR_W'(start);
            pend   <= 1'b0;
            if (go_read) begin
              state <= S_RDWAIT;
            end else if (go_shift) begin
              state <= S_SHIFT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RDWAIT: begin
          res_rd <= rdata;
          state  <= S_DONE;
        end
        S_SHIFT: begin
          if (left != '0) begin
            pend    <= 1'b1;
            left    <= left - 1'b1;
            wr_addr <= is_ins ? rd_idx + 1'b1 : rd_idx - 1'b1;
            rd_idx  <= is_ins ? rd_idx - 1'b1 : rd_idx + 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          count <= is_ins ? count + 1'b1 : count - 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid = (state == S_DONE);
  assign res.rd    = res_rd;
  assign res.st    = res_st;
  assign res.count = count;

endmodule
